// ===== rtl/packet_fifo_with_crc16_top_defines.svh =====
// Assertion macros for the packet queue. They expand to concurrent
// assertions in simulation and to nothing in synthesis.
`ifndef PACKET_FIFO_WITH_CRC16_TOP_DEFINES_SVH
`define PACKET_FIFO_WITH_CRC16_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfc: implication check failed");
`define PFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfc: next-cycle check failed");
`else
`define PFC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/pfc_pkg.sv =====
`timescale 1ns / 1ps

package pfc_pkg;

    localparam int DEF_QUEUE_DEPTH   = 8;
    localparam int DEF_PAYLOAD_BYTES = 4;
    localparam int JOBQ_DEPTH        = 2;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        OP_ENQ_SIGN  = 2'd0,
        OP_ENQ_GIVEN = 2'd1,
        OP_DEQ       = 2'd2,
        OP_PEEK      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_CRC    = 3'd1,
        ST_UPDATE = 3'd2,
        ST_READ   = 3'd3,
        ST_RESP   = 3'd4
    } t_state;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  cmd_byte;
        logic [31:0] payload_bits;
        logic [15:0] given_crc;
    } t_in;

    typedef struct packed {
        logic        accepted;
        logic        head_valid;
        logic [7:0]  head_cmd;
        logic [31:0] head_payload;
        logic [15:0] head_crc;
        logic        head_crc_ok;
        logic [2:0]  occupancy;
    } t_out;

    // A classified command as it waits between the front and the back.
    typedef struct packed {
        t_op         op;
        logic        is_enq;
        logic [7:0]  cmd_byte;
        logic [31:0] payload_bits;
        logic [15:0] given_crc;
    } t_job;

    typedef struct packed {
        logic [7:0]  cmd_byte;
        logic [31:0] payload_bits;
        logic [15:0] crc;
        logic        crc_ok;
    } t_slot;

    // One byte of reflected CRC-16/ARC, eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/pfc_front.sv =====
`timescale 1ns / 1ps

module pfc_front #(
    parameter int PAYLOAD_BYTES = pfc_pkg::DEF_PAYLOAD_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pfc_pkg::t_in  i_item,
    output logic          o_job_valid,
    output pfc_pkg::t_job o_job,
    input  logic          i_job_pop
);
    import pfc_pkg::*;

    localparam int QI_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
    localparam int QC_W = $clog2(JOBQ_DEPTH + 1);
    localparam logic [31:0] PAY_MASK = (PAYLOAD_BYTES >= 4) ? 32'hFFFF_FFFF :
        32'((64'd1 << (8 * PAYLOAD_BYTES)) - 64'd1);

    t_job            r_q [JOBQ_DEPTH];
    logic [QI_W-1:0] r_rd_idx, n_rd_idx;
    logic [QI_W-1:0] r_wr_idx, n_wr_idx;
    logic [QC_W-1:0] r_count,  n_count;

    logic w_push;
    logic w_pop;
    t_job w_job;

    // Classify the incoming command and trim the payload to its stored width.
    always_comb begin
        w_job.op           = t_op'(i_item.op);
        w_job.is_enq       = (w_job.op == OP_ENQ_SIGN) || (w_job.op == OP_ENQ_GIVEN);
        w_job.cmd_byte     = i_item.cmd_byte;
        w_job.payload_bits = i_item.payload_bits & PAY_MASK;
        w_job.given_crc    = i_item.given_crc;
    end

    assign busy        = (r_count == QC_W'(JOBQ_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_q[r_rd_idx];
    assign w_push      = start & ~busy;
    assign w_pop       = i_job_pop & o_job_valid;

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        if (w_push) begin
            n_wr_idx = (r_wr_idx == QI_W'(JOBQ_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
        end
        if (w_pop) begin
            n_rd_idx = (r_rd_idx == QI_W'(JOBQ_DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_count  <= '0;
        end else begin
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_idx] <= w_job;
        end
    end

endmodule

// ===== rtl/pfc_back.sv =====
`timescale 1ns / 1ps

module pfc_back #(
    parameter int QUEUE_DEPTH   = pfc_pkg::DEF_QUEUE_DEPTH,
    parameter int PAYLOAD_BYTES = pfc_pkg::DEF_PAYLOAD_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  pfc_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_strobe,
    output pfc_pkg::t_out o_result
);
    import pfc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam int BC_W  = $clog2(PAYLOAD_BYTES + 1);

    t_state           r_state, n_state;
    t_job             r_job, n_job;
    logic [15:0]      r_crc, n_crc;
    logic [31:0]      r_shift, n_shift;
    logic [BC_W-1:0]  r_byte_cnt, n_byte_cnt;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic             r_accepted, n_accepted;
    t_slot            r_rd_slot;
    t_slot            r_mem [QUEUE_DEPTH];

    logic             w_empty;
    logic             w_full;
    logic [PTR_W-1:0] w_wp_next;
    logic [PTR_W-1:0] w_rp_next;
    logic [7:0]       w_crc_byte;
    logic             w_wr_en;
    t_slot            w_wr_slot;
    logic [CNT_W-1:0] w_occ;

    assign w_wp_next = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign w_rp_next = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign w_empty   = (r_rp == r_wp);
    assign w_full    = (w_wp_next == r_rp);

    // The command byte goes first, then payload bytes from the low end.
    assign w_crc_byte = (r_byte_cnt == '0) ? r_job.cmd_byte : r_shift[7:0];

    always_comb begin
        w_wr_slot.cmd_byte     = r_job.cmd_byte;
        w_wr_slot.payload_bits = r_job.payload_bits;
        w_wr_slot.crc          = (r_job.op == OP_ENQ_SIGN) ? r_crc : r_job.given_crc;
        w_wr_slot.crc_ok       = (w_wr_slot.crc == r_crc);
    end

    always_comb begin
        if (r_wp >= r_rp) begin
            w_occ = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            w_occ = {1'b0, r_wp} + CNT_W'(QUEUE_DEPTH) - {1'b0, r_rp};
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.is_enq ? ST_CRC : ST_UPDATE;
                end
            end
            ST_CRC: begin
                if (r_byte_cnt == BC_W'(PAYLOAD_BYTES)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: n_state = ST_READ;
            ST_READ:   n_state = ST_RESP;
            ST_RESP:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb begin
        n_job      = r_job;
        n_crc      = r_crc;
        n_shift    = r_shift;
        n_byte_cnt = r_byte_cnt;
        n_rp       = r_rp;
        n_wp       = r_wp;
        n_accepted = r_accepted;
        w_wr_en    = 1'b0;
        o_job_pop  = 1'b0;
        o_strobe   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop  = 1'b1;
                    n_job      = i_job;
                    n_crc      = '0;
                    n_shift    = i_job.payload_bits;
                    n_byte_cnt = '0;
                end
            end
            ST_CRC: begin
                n_crc      = crc_byte(r_crc, w_crc_byte);
                n_byte_cnt = r_byte_cnt + 1'b1;
                if (r_byte_cnt != '0) begin
                    n_shift = r_shift >> 8;
                end
            end
            ST_UPDATE: begin
                n_accepted = 1'b0;
                if (r_job.is_enq) begin
                    if (!w_full) begin
                        w_wr_en    = 1'b1;
                        n_wp       = w_wp_next;
                        n_accepted = 1'b1;
                    end
                end else if (r_job.op == OP_DEQ) begin
                    if (!w_empty) begin
                        n_rp       = w_rp_next;
                        n_accepted = 1'b1;
                    end
                end
            end
            ST_READ: begin
                n_accepted = r_accepted;
            end
            ST_RESP: begin
                o_strobe = 1'b1;
            end
            default: begin
                n_accepted = r_accepted;
            end
        endcase
    end

    always_comb begin
        o_result.accepted     = r_accepted;
        o_result.head_valid   = ~w_empty;
        o_result.head_cmd     = w_empty ? 8'h00  : r_rd_slot.cmd_byte;
        o_result.head_payload = w_empty ? 32'h0  : r_rd_slot.payload_bits;
        o_result.head_crc     = w_empty ? 16'h0  : r_rd_slot.crc;
        o_result.head_crc_ok  = w_empty ? 1'b0   : r_rd_slot.crc_ok;
        o_result.occupancy    = 3'(w_occ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rp       <= '0;
            r_wp       <= '0;
            r_accepted <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rp       <= n_rp;
            r_wp       <= n_wp;
            r_accepted <= n_accepted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_crc      <= n_crc;
        r_shift    <= n_shift;
        r_byte_cnt <= n_byte_cnt;
    end

    // Packet store: one write port at the write pointer, one registered read
    // port at the read pointer.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wp] <= w_wr_slot;
        end
        if (r_state == ST_READ) begin
            r_rd_slot <= r_mem[r_rp];
        end
    end

endmodule

// ===== rtl/packet_fifo_with_crc16_top.sv =====
`timescale 1ns / 1ps

// Packet queue with CRC-16/ARC signing. Present a command on i_item and raise
// start; it is taken at a rising edge where start is high and busy is low.
// The op field enqueues and signs a packet, enqueues a packet carrying its own
// CRC, dequeues the front packet, or only peeks. For every accepted item
// exactly one result appears on o_result for a single cycle with o_strobe
// high; the receiver cannot stall, so it must take the result in that cycle.
// The result shows whether the action took effect, the front packet after the
// action (zeros when the queue is empty), whether that packet's stored CRC
// matched the CRC computed when it was enqueued, and the occupancy. The queue
// holds at most QUEUE_DEPTH minus one packets; an enqueue to a full queue and
// a dequeue from an empty queue report accepted low and change nothing.
// A two-entry command queue in front lets up to two items wait while the back
// end works, and busy rises only when both entries are taken. The back end
// handles one item at a time. It first takes a command from the command
// queue; for an enqueue the CRC unit then folds in one byte per cycle over
// the command byte and PAYLOAD_BYTES payload bytes. Then follow the store
// update, the registered store read of the front slot and the result. An
// item also waits while items ahead of it pass through the back end.
// No clearing pass is needed after reset: only slots written since are read.

module packet_fifo_with_crc16_top #(
    parameter int QUEUE_DEPTH   = pfc_pkg::DEF_QUEUE_DEPTH,
    parameter int PAYLOAD_BYTES = pfc_pkg::DEF_PAYLOAD_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pfc_pkg::t_in  i_item,
    output logic          o_strobe,
    output pfc_pkg::t_out o_result
);
    import pfc_pkg::*;

    `include "packet_fifo_with_crc16_top_defines.svh"

    logic w_job_valid;
    t_job w_job;
    logic w_job_pop;

    // Front end: takes commands, classifies them and queues them.
    pfc_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    // Back end: computes the CRC, updates the packet store and reports.
    pfc_back #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // A result is never shown in back-to-back cycles.
    `PFC_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)
    // The back end takes a command only when the front end offers one.
    `PFC_ASSERT_IMPL(a_pop_has_job, i_clk, i_rst_n, w_job_pop, w_job_valid)
    // An empty queue reports a zeroed front packet.
    `PFC_ASSERT_IMPL(a_empty_head_zero, i_clk, i_rst_n, o_strobe && !o_result.head_valid, (o_result.head_cmd == 8'h00) && (o_result.head_payload == 32'h0) && (o_result.head_crc == 16'h0) && !o_result.head_crc_ok)
    // Without wrap of the occupancy field, a valid head means a nonzero count.
    `PFC_ASSERT_IMPL(a_occ_matches_head, i_clk, i_rst_n, o_strobe && (QUEUE_DEPTH <= 8), o_result.head_valid == (o_result.occupancy != 3'd0))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pfc_pkg::*;

    // The queue keeps one slot free, so it is full at QDEPTH minus one packets.
    localparam int QDEPTH         = DEF_QUEUE_DEPTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_ITEMS   = 1550;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_in   i_item  = '0;
    logic  busy;
    logic  o_strobe;
    t_out  o_result;

    packet_fifo_with_crc16_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Commands waiting to be presented, and the front-of-queue views that the
    // accepted commands are predicted to produce, oldest first.
    t_in  commands_to_send[$];
    t_out expected_heads[$];

    // Shadow copy of the packet store and its ring pointers.
    logic [7:0]  shadow_cmd[QDEPTH];
    logic [31:0] shadow_payload[QDEPTH];
    logic [15:0] shadow_crc[QDEPTH];
    logic        shadow_crc_ok[QDEPTH];
    int          shadow_rd = 0;
    int          shadow_wr = 0;

    // Activity counters for the closing summary.
    int commands_taken   = 0;
    int results_checked  = 0;
    int packets_stored   = 0;
    int refused_full     = 0;
    int packets_removed  = 0;
    int dequeues_empty   = 0;
    int peeks_done       = 0;
    int bad_crc_stored   = 0;
    int mismatch_count   = 0;
    int total_commands   = 0;

    // CRC-16/ARC taken bit by bit, least significant bit first: the command
    // byte, then payload byte 0 upward. This matches the byte-wise reflected
    // form with polynomial 0xA001 and a zero start value.
    function automatic logic [15:0] arc16_of_packet(logic [7:0] cmd, logic [31:0] payload);
        logic [39:0] stream;
        logic [15:0] acc;
        logic        feedback;
        stream = {payload, cmd};
        acc    = '0;
        for (int b = 0; b < 40; b++) begin
            feedback = acc[0] ^ stream[b];
            acc      = acc >> 1;
            if (feedback) begin
                acc = acc ^ 16'hA001;
            end
        end
        return acc;
    endfunction

    // Applies one command to the shadow queue and returns the front-of-queue
    // view that the block must report for it.
    function automatic t_out apply_queue_command(t_in cmd_item);
        t_out        view;
        int          next_wr;
        logic [15:0] fresh_crc;
        logic [15:0] kept_crc;
        view    = '0;
        next_wr = (shadow_wr + 1) % QDEPTH;
        case (t_op'(cmd_item.op))
            OP_ENQ_SIGN, OP_ENQ_GIVEN: begin
                if (next_wr != shadow_rd) begin
                    fresh_crc = arc16_of_packet(cmd_item.cmd_byte, cmd_item.payload_bits);
                    kept_crc  = (t_op'(cmd_item.op) == OP_ENQ_SIGN) ? fresh_crc
                                                                     : cmd_item.given_crc;
                    shadow_cmd[shadow_wr]     = cmd_item.cmd_byte;
                    shadow_payload[shadow_wr] = cmd_item.payload_bits;
                    shadow_crc[shadow_wr]     = kept_crc;
                    shadow_crc_ok[shadow_wr]  = (kept_crc == fresh_crc);
                    if (kept_crc != fresh_crc) begin
                        bad_crc_stored++;
                    end
                    shadow_wr     = next_wr;
                    view.accepted = 1'b1;
                    packets_stored++;
                end else begin
                    refused_full++;
                end
            end
            OP_DEQ: begin
                if (shadow_rd != shadow_wr) begin
                    shadow_rd     = (shadow_rd + 1) % QDEPTH;
                    view.accepted = 1'b1;
                    packets_removed++;
                end else begin
                    dequeues_empty++;
                end
            end
            default: begin
                peeks_done++;
            end
        endcase
        if (shadow_rd != shadow_wr) begin
            view.head_valid   = 1'b1;
            view.head_cmd     = shadow_cmd[shadow_rd];
            view.head_payload = shadow_payload[shadow_rd];
            view.head_crc     = shadow_crc[shadow_rd];
            view.head_crc_ok  = shadow_crc_ok[shadow_rd];
        end
        view.occupancy = 3'((shadow_wr - shadow_rd + QDEPTH) % QDEPTH);
        return view;
    endfunction

    function automatic t_in make_command(t_op op, logic [7:0] cmd, logic [31:0] payload,
                                         logic [15:0] given);
        t_in c;
        c.op           = op;
        c.cmd_byte     = cmd;
        c.payload_bits = payload;
        c.given_crc    = given;
        return c;
    endfunction

    function automatic t_in random_command();
        return make_command(t_op'($urandom_range(0, 3)), 8'($urandom), $urandom,
                            16'($urandom));
    endfunction

    // Driver. A command stays on the bus until the monitor reports that it was
    // taken; then a random gap may follow. Runs of commands with no gap at all
    // come in phases so that back-to-back traffic fills the block's two-entry
    // command buffer and drives busy high.
    logic command_taken = 1'b0;
    bit   presenting    = 1'b0;
    bit   no_gap_phase  = 1'b0;
    int   gap_left      = 0;
    t_in  current_command;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (presenting && command_taken) begin
                presenting = 1'b0;
                gap_left   = no_gap_phase ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 63) == 0) begin
                    no_gap_phase = !no_gap_phase;
                end
            end
            if (!presenting) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (commands_to_send.size() > 0) begin
                    current_command = commands_to_send.pop_front();
                    presenting      = 1'b1;
                end
            end
        end
        start  <= presenting;
        // While start is low the command bus carries noise the block must ignore.
        i_item <= presenting ? current_command : random_command();
    end

    // Monitor. At each rising edge it first checks a result that is leaving
    // the block, then predicts the result of a command that is being taken.
    always @(posedge i_clk) begin
        t_out expected;
        if (!i_rst_n) begin
            command_taken <= 1'b0;
        end else begin
            if (o_strobe) begin
                if (expected_heads.size() == 0) begin
                    $display("%0t: result with none expected, got %p", $time, o_result);
                    mismatch_count++;
                end else begin
                    expected = expected_heads.pop_front();
                    results_checked++;
                    if (o_result.accepted !== expected.accepted) begin
                        $display("%0t: accepted mismatch, expected %0b, got %0b",
                                 $time, expected.accepted, o_result.accepted);
                        mismatch_count++;
                    end
                    if (o_result.head_valid !== expected.head_valid) begin
                        $display("%0t: head_valid mismatch, expected %0b, got %0b",
                                 $time, expected.head_valid, o_result.head_valid);
                        mismatch_count++;
                    end
                    if (o_result.head_cmd !== expected.head_cmd) begin
                        $display("%0t: head_cmd mismatch, expected %02h, got %02h",
                                 $time, expected.head_cmd, o_result.head_cmd);
                        mismatch_count++;
                    end
                    if (o_result.head_payload !== expected.head_payload) begin
                        $display("%0t: head_payload mismatch, expected %08h, got %08h",
                                 $time, expected.head_payload, o_result.head_payload);
                        mismatch_count++;
                    end
                    if (o_result.head_crc !== expected.head_crc) begin
                        $display("%0t: head_crc mismatch, expected %04h, got %04h",
                                 $time, expected.head_crc, o_result.head_crc);
                        mismatch_count++;
                    end
                    if (o_result.head_crc_ok !== expected.head_crc_ok) begin
                        $display("%0t: head_crc_ok mismatch, expected %0b, got %0b",
                                 $time, expected.head_crc_ok, o_result.head_crc_ok);
                        mismatch_count++;
                    end
                    if (o_result.occupancy !== expected.occupancy) begin
                        $display("%0t: occupancy mismatch, expected %0d, got %0d",
                                 $time, expected.occupancy, o_result.occupancy);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                expected_heads.push_back(apply_queue_command(i_item));
                commands_taken++;
            end
            command_taken <= start && !busy;
        end
    end

    // Watchdog. Any cycle in which a command is taken or a result appears
    // counts as progress; a long run without either ends the test.
    int stalled_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                stalled_cycles <= 0;
            end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end else begin
                stalled_cycles <= stalled_cycles + 1;
            end
        end
    end

    initial begin
        logic [15:0] good_crc;
        bit          fill_phase;
        int          phase_left;
        int          roll;

        // Directed part: empty-queue dequeue and peek, field extremes, a
        // presigned packet with a matching and with a mismatching CRC, filling
        // the queue to its limit, refused enqueues of both kinds, and draining.
        commands_to_send.push_back(make_command(OP_PEEK, 8'h00, 32'h0, 16'h0));
        commands_to_send.push_back(make_command(OP_DEQ, 8'hFF, 32'hFFFFFFFF, 16'hFFFF));
        commands_to_send.push_back(make_command(OP_ENQ_SIGN, 8'h00, 32'h0, 16'hFFFF));
        commands_to_send.push_back(make_command(OP_ENQ_SIGN, 8'hFF, 32'hFFFFFFFF, 16'h0));
        good_crc = arc16_of_packet(8'hA5, 32'h12345678);
        commands_to_send.push_back(make_command(OP_ENQ_GIVEN, 8'hA5, 32'h12345678, good_crc));
        commands_to_send.push_back(make_command(OP_ENQ_GIVEN, 8'hA5, 32'h12345678,
                                                good_crc ^ 16'h8001));
        commands_to_send.push_back(make_command(OP_ENQ_GIVEN, 8'h5A, 32'h80000001, 16'hFFFF));
        commands_to_send.push_back(make_command(OP_ENQ_SIGN, 8'h01, 32'h000000FF, 16'h0));
        commands_to_send.push_back(make_command(OP_ENQ_SIGN, 8'h80, 32'hFF000000, 16'h0));
        // The queue now holds its maximum, so both enqueue kinds are refused.
        commands_to_send.push_back(make_command(OP_ENQ_SIGN, 8'h3C, 32'hDEADBEEF, 16'h0));
        commands_to_send.push_back(make_command(OP_ENQ_GIVEN, 8'hC3, 32'hCAFEF00D, 16'h1234));
        commands_to_send.push_back(make_command(OP_PEEK, 8'hFF, 32'hFFFFFFFF, 16'hFFFF));
        for (int n = 0; n < QDEPTH - 1; n++) begin
            commands_to_send.push_back(make_command(OP_DEQ, 8'h00, 32'h0, 16'h0));
        end
        commands_to_send.push_back(make_command(OP_DEQ, 8'h00, 32'h0, 16'h0));
        commands_to_send.push_back(make_command(OP_PEEK, 8'h00, 32'h0, 16'h0));
        // An all-zero packet has a zero CRC, so a presigned zero CRC matches.
        commands_to_send.push_back(make_command(OP_ENQ_GIVEN, 8'h00, 32'h0, 16'h0));
        commands_to_send.push_back(make_command(OP_DEQ, 8'h00, 32'h0, 16'h0));

        // Random part. Filling and draining phases alternate so that the queue
        // spends time both full and empty; a few fully random commands mix in.
        fill_phase = 1'b1;
        phase_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                fill_phase = !fill_phase;
                phase_left = $urandom_range(10, 40);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                commands_to_send.push_back(random_command());
            end else if (roll < (fill_phase ? 65 : 30)) begin
                if ($urandom_range(0, 1) == 0) begin
                    commands_to_send.push_back(make_command(OP_ENQ_SIGN, 8'($urandom),
                                                            $urandom, 16'($urandom)));
                end else begin
                    commands_to_send.push_back(make_command(OP_ENQ_GIVEN, 8'($urandom),
                                                            $urandom, 16'($urandom)));
                    // Half of the presigned packets carry their correct CRC.
                    if ($urandom_range(0, 1) == 0) begin
                        commands_to_send[$].given_crc =
                            arc16_of_packet(commands_to_send[$].cmd_byte,
                                            commands_to_send[$].payload_bits);
                    end
                end
            end else if (roll < 88) begin
                commands_to_send.push_back(make_command(OP_DEQ, 8'($urandom), $urandom,
                                                        16'($urandom)));
            end else begin
                commands_to_send.push_back(make_command(OP_PEEK, 8'($urandom), $urandom,
                                                        16'($urandom)));
            end
        end
        total_commands = commands_to_send.size();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every command is taken and every result has come back,
        // then let the block sit idle for a while to catch stray strobes.
        while (commands_taken < total_commands || expected_heads.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d commands: %0d packets stored, %0d refused as full, %0d removed.",
                 commands_taken, packets_stored, refused_full, packets_removed);
        $display("Also %0d dequeues on empty, %0d peeks, %0d bad CRCs stored; %0d results.",
                 dequeues_empty, peeks_done, bad_crc_stored, results_checked);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
